// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the factorizer.
// Needs nothing else; each macro takes a label, clock, reset and the terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TDF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define TDF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/tdf_pkg.sv -----
// Package for the trial-division factorizer: widths, codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package tdf_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int EXP_WIDTH       = 6;
   localparam int STATUS_WIDTH    = 2;
   localparam int REQ_DATA_WIDTH  = 2 * DATA_WIDTH;
   localparam int RSP_DATA_WIDTH  = ((DATA_WIDTH + EXP_WIDTH + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH   = RSP_DATA_WIDTH - DATA_WIDTH - EXP_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DATA_WIDTH + 1);

   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd2;

   localparam logic CMD_FACTOR    = 1'b0;
   localparam logic CMD_VALUATION = 1'b1;

   localparam logic [DATA_WIDTH-1:0] TRIAL_EVEN = DATA_WIDTH'(2);
   localparam logic [DATA_WIDTH-1:0] TRIAL_ODD  = DATA_WIDTH'(3);
   localparam logic [DATA_WIDTH-1:0] TRIAL_STEP = DATA_WIDTH'(2);

   typedef struct packed {
      logic                    load;
      logic                    load_special;
      logic [STATUS_WIDTH-1:0] special_status;
      logic                    div_start;
      logic                    strip_step;
      logic                    t_advance;
      logic                    stash;
      logic                    stash_final;
      logic                    flush;
   } dp_cmd_type;

   typedef struct packed {
      logic value_zero;
      logic value_one;
      logic divisor_low;
      logic cmd_valuation;
      logic div_done;
      logic rem_zero;
      logic t_gt_q;
      logic t_is_two;
      logic rem_gt_one;
      logic stash_ready;
      logic flush_ready;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- sv/tdf_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on tdf_pkg.
`default_nettype none

module tdf_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [tdf_pkg::DATA_WIDTH-1:0] dividend,
   input  wire  [tdf_pkg::DATA_WIDTH-1:0] divisor,
   output logic                         done,
   output logic [tdf_pkg::DATA_WIDTH-1:0] quotient,
   output logic [tdf_pkg::DATA_WIDTH-1:0] remainder
);
   import tdf_pkg::*;

   logic [DATA_WIDTH-1:0]      part_ff, part_in;
   logic [DATA_WIDTH-1:0]      quo_ff, quo_in;
   logic [DATA_WIDTH-1:0]      dvs_ff, dvs_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       done_ff, done_in;
   logic [DATA_WIDTH:0]        trial;
   logic [DATA_WIDTH:0]        diff;

   always_comb begin
      trial    = {part_ff, quo_ff[DATA_WIDTH-1]};
      diff     = trial - {1'b0, dvs_ff};
      part_in  = part_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         part_in  = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         count_in = DIV_COUNT_WIDTH'(DATA_WIDTH);
      end else if (count_ff != '0) begin
         if (!diff[DATA_WIDTH]) begin
            part_in = diff[DATA_WIDTH-1:0];
         end else begin
            part_in = trial[DATA_WIDTH-1:0];
         end
         quo_in   = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
         count_in = count_ff - DIV_COUNT_WIDTH'(1);
         done_in  = (count_ff == DIV_COUNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff;

endmodule

`default_nettype wire

// ----- sv/tdf_datapath.sv -----
// Datapath: remainder, trial divisor, exponent count, pending result and
// the output register. Depends on tdf_pkg and tdf_divider.
`default_nettype none

module tdf_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  tdf_pkg::dp_cmd_type                cmd,
   output tdf_pkg::dp_status_type             status,
   input  wire                                req_tuser,
   input  wire  [tdf_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [tdf_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   output logic [tdf_pkg::STATUS_WIDTH-1:0]   rsp_tuser
);
   import tdf_pkg::*;

   logic [DATA_WIDTH-1:0]   value;
   logic [DATA_WIDTH-1:0]   divisor;
   logic [DATA_WIDTH-1:0]   div_q;
   logic [DATA_WIDTH-1:0]   div_r;
   logic                    div_done;
   logic                    slot_free;

   logic [DATA_WIDTH-1:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]   t_ff, t_in;
   logic [EXP_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]   hold_prime_ff, hold_prime_in;
   logic [EXP_WIDTH-1:0]    hold_exp_ff, hold_exp_in;
   logic [STATUS_WIDTH-1:0] hold_status_ff, hold_status_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic [DATA_WIDTH-1:0]   out_prime_ff, out_prime_in;
   logic [EXP_WIDTH-1:0]    out_exp_ff, out_exp_in;
   logic [STATUS_WIDTH-1:0] out_status_ff, out_status_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_valid_ff, out_valid_in;

   assign value   = req_tdata[DATA_WIDTH-1:0];
   assign divisor = req_tdata[REQ_DATA_WIDTH-1:DATA_WIDTH];

   tdf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rem_ff),
      .divisor   (t_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      status.value_zero    = (value == '0);
      status.value_one     = (value == DATA_WIDTH'(1));
      status.divisor_low   = (divisor < TRIAL_EVEN);
      status.cmd_valuation = (req_tuser == CMD_VALUATION);
      status.div_done      = div_done;
      status.rem_zero      = (div_r == '0);
      status.t_gt_q        = (t_ff > div_q);
      status.t_is_two      = (t_ff == TRIAL_EVEN);
      status.rem_gt_one    = (rem_ff > DATA_WIDTH'(1));
      status.stash_ready   = !hold_valid_ff || slot_free;
      status.flush_ready   = slot_free;
   end

   always_comb begin
      rem_in         = rem_ff;
      t_in           = t_ff;
      cnt_in         = cnt_ff;
      hold_prime_in  = hold_prime_ff;
      hold_exp_in    = hold_exp_ff;
      hold_status_in = hold_status_ff;
      hold_valid_in  = hold_valid_ff;
      out_prime_in   = out_prime_ff;
      out_exp_in     = out_exp_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;

      if (cmd.load) begin
         rem_in = value;
         t_in   = (req_tuser == CMD_VALUATION) ? divisor : TRIAL_EVEN;
         cnt_in = '0;
      end
      if (cmd.strip_step) begin
         rem_in = div_q;
         cnt_in = cnt_ff + EXP_WIDTH'(1);
      end
      if (cmd.t_advance) begin
         t_in   = (t_ff == TRIAL_EVEN) ? TRIAL_ODD : t_ff + TRIAL_STEP;
         cnt_in = '0;
      end
      if (cmd.load_special) begin
         hold_prime_in  = '0;
         hold_exp_in    = '0;
         hold_status_in = cmd.special_status;
         hold_valid_in  = 1'b1;
      end
      if (cmd.stash) begin
         if (hold_valid_ff) begin
            out_prime_in  = hold_prime_ff;
            out_exp_in    = hold_exp_ff;
            out_status_in = hold_status_ff;
            out_last_in   = 1'b0;
            out_valid_in  = 1'b1;
         end
         hold_prime_in  = cmd.stash_final ? rem_ff : t_ff;
         hold_exp_in    = cmd.stash_final ? EXP_WIDTH'(1) : cnt_ff;
         hold_status_in = ST_OK;
         hold_valid_in  = 1'b1;
      end
      if (cmd.flush) begin
         out_prime_in  = hold_prime_ff;
         out_exp_in    = hold_exp_ff;
         out_status_in = hold_status_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      t_ff           <= t_in;
      cnt_ff         <= cnt_in;
      hold_prime_ff  <= hold_prime_in;
      hold_exp_ff    <= hold_exp_in;
      hold_status_ff <= hold_status_in;
      out_prime_ff   <= out_prime_in;
      out_exp_ff     <= out_exp_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_WIDTH{1'b0}}, out_exp_ff, out_prime_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

// ----- sv/tdf_controller.sv -----
// Controller state machine: sequences the trial loop and result transfers.
// Depends on tdf_pkg.
`default_nettype none

module tdf_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  tdf_pkg::dp_status_type  status,
   output tdf_pkg::dp_cmd_type     cmd
);
   import tdf_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_STASH = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valuation_ff, valuation_in;
   logic       strip_ff, strip_in;
   logic       final_ff, final_in;

   always_comb begin
      state_in     = state_ff;
      valuation_in = valuation_ff;
      strip_in     = strip_ff;
      final_in     = final_ff;
      cmd          = '0;
      req_tready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (status.value_zero || (status.cmd_valuation && status.divisor_low)) begin
                  cmd.load_special   = 1'b1;
                  cmd.special_status = ST_INVALID;
                  state_in           = S_FLUSH;
               end else if (!status.cmd_valuation && status.value_one) begin
                  cmd.load_special   = 1'b1;
                  cmd.special_status = ST_EMPTY;
                  state_in           = S_FLUSH;
               end else begin
                  cmd.load     = 1'b1;
                  valuation_in = status.cmd_valuation;
                  strip_in     = status.cmd_valuation;
                  final_in     = 1'b0;
                  state_in     = S_START;
               end
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (status.div_done) begin
               if (strip_ff) begin
                  if (status.rem_zero) begin
                     cmd.strip_step = 1'b1;
                     state_in       = S_START;
                  end else begin
                     final_in = 1'b0;
                     state_in = S_STASH;
                  end
               end else if (!status.t_is_two && status.t_gt_q) begin
                  if (status.rem_gt_one) begin
                     final_in = 1'b1;
                     state_in = S_STASH;
                  end else begin
                     state_in = S_FLUSH;
                  end
               end else if (status.rem_zero) begin
                  cmd.strip_step = 1'b1;
                  strip_in       = 1'b1;
                  state_in       = S_START;
               end else begin
                  cmd.t_advance = 1'b1;
                  state_in      = S_START;
               end
            end
         end
         S_STASH: begin
            if (status.stash_ready) begin
               cmd.stash       = 1'b1;
               cmd.stash_final = final_ff;
               if (final_ff || valuation_ff) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.t_advance = 1'b1;
                  strip_in      = 1'b0;
                  state_in      = S_START;
               end
            end
         end
         S_FLUSH: begin
            if (status.flush_ready) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valuation_ff <= 1'b0;
         strip_ff     <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valuation_ff <= valuation_in;
         strip_ff     <= strip_in;
         final_ff     <= final_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/trial_division_factorizer.sv -----
// Top level of the trial-division factorizer: controller plus datapath.
// Depends on tdf_pkg, tdf_controller, tdf_datapath (and tdf_divider).
//
//   channel  dir  tvalid/tready  tdata                      tuser       tlast
//   req      in   req_           [31:0] value [63:32] div   cmd         -
//   rsp      out  rsp_           [31:0] prime [37:32] exp   status      last
//
// Each trial candidate costs one 32-step restoring division, started in S_START
// and awaited in S_WAIT. Special operands skip the division and go straight to
// S_FLUSH. One item at a time; req_tready is high only when idle. Reset is
// synchronous and clears all control state.
// A stalled rsp_ holds the datapath at the next result transfer.
`default_nettype none

module trial_division_factorizer (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [tdf_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // value, divisor
   input  wire                                req_tuser,  // cmd
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [tdf_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,  // prime, exponent, pad
   output logic                               rsp_tlast,
   output logic [tdf_pkg::STATUS_WIDTH-1:0]   rsp_tuser   // status
);
   import tdf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tdf_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tdf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- sv/tdf_checker.sv -----
// Port-level checker for the factorizer, bound to the top level.
// Depends on tdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tdf_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [tdf_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input wire                                rsp_tlast,
   input wire [tdf_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);
   import tdf_pkg::*;

   logic                                 req_xfer;
   logic                                 rsp_special;
   logic                                 rsp_stall;
   logic [RSP_DATA_WIDTH+STATUS_WIDTH:0] rsp_word;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_special = rsp_tvalid && (rsp_tuser != ST_OK);
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_word    = {rsp_tdata, rsp_tlast, rsp_tuser};

   // one item in flight: intake closes after a transfer
   `TDF_ASSERT_NXT(a_intake_closes, clock, reset, req_xfer, !req_tready)

   // when idle only a final result can still be waiting
   `TDF_ASSERT_IMP(a_idle_only_last, clock, reset, rsp_tvalid && req_tready, rsp_tlast)

   // empty and invalid results are single, last and zero
   `TDF_ASSERT_IMP(a_special_result, clock, reset, rsp_special, rsp_tlast && rsp_tdata == '0)

   // stalled result holds
   `TDF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

endmodule

bind trial_division_factorizer tdf_checker u_checker (.*);

`default_nettype wire

// ----- verif/trial_division_factorizer_test.sv -----
// Self-checking testbench for trial_division_factorizer: directed and random
// factorise/valuation requests, results checked against an in-bench predictor.
// Depends on tdf_pkg and the trial_division_factorizer RTL.
module trial_division_factorizer_test;
   import tdf_pkg::*;

   typedef struct {
      logic [DATA_WIDTH-1:0]   prime;
      logic [EXP_WIDTH-1:0]    exponent;
      logic                    last;
      logic [STATUS_WIDTH-1:0] status;
   } factor_result_type;

   class factor_scoreboard_type;
      factor_result_type pending[$];
      int unsigned       errors;

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      function void push_factor(logic [DATA_WIDTH-1:0] prime, logic [EXP_WIDTH-1:0] exponent,
                                logic last, logic [STATUS_WIDTH-1:0] status);
         factor_result_type r;
         r.prime    = prime;
         r.exponent = exponent;
         r.last     = last;
         r.status   = status;
         pending.insert(pending.size(), r);
      endfunction

      // divides base out of rem completely, returns the multiplicity
      function logic [EXP_WIDTH-1:0] strip_factor(inout logic [DATA_WIDTH-1:0] rem,
                                                  input logic [DATA_WIDTH-1:0] base);
         logic [EXP_WIDTH-1:0] count;
         count = '0;
         while (rem % base == 0) begin
            rem   = rem / base;
            count = count + 1'b1;
         end
         return count;
      endfunction

      function void note_request(logic cmd, logic [DATA_WIDTH-1:0] value,
                                 logic [DATA_WIDTH-1:0] divisor);
         logic [DATA_WIDTH-1:0] rem;
         logic [DATA_WIDTH-1:0] trial;
         logic [EXP_WIDTH-1:0]  count;
         if (value == 0) begin
            push_factor('0, '0, 1'b1, ST_INVALID);
         end else if (cmd == CMD_VALUATION) begin
            if (divisor < 2) begin
               push_factor('0, '0, 1'b1, ST_INVALID);
            end else begin
               rem   = value;
               count = strip_factor(rem, divisor);
               push_factor(divisor, count, 1'b1, ST_OK);
            end
         end else if (value == 1) begin
            push_factor('0, '0, 1'b1, ST_EMPTY);
         end else begin
            rem = value;
            if (!rem[0]) begin
               count = strip_factor(rem, TRIAL_EVEN);
               push_factor(TRIAL_EVEN, count, 1'b0, ST_OK);
            end
            trial = TRIAL_ODD;
            while (trial <= rem / trial) begin
               if (rem % trial == 0) begin
                  count = strip_factor(rem, trial);
                  push_factor(trial, count, 1'b0, ST_OK);
               end
               trial = trial + TRIAL_STEP;
            end
            if (rem > 1)
               push_factor(rem, EXP_WIDTH'(1), 1'b0, ST_OK);
            pending[pending.size()-1].last = 1'b1;
         end
      endfunction

      task check_response(logic [DATA_WIDTH-1:0] prime, logic [EXP_WIDTH-1:0] exponent,
                          logic last, logic [STATUS_WIDTH-1:0] status);
         factor_result_type exp_r;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result prime %0d exp %0d", prime, exponent));
         end else begin
            exp_r = pending.pop_front();
            if (prime !== exp_r.prime)
               report_mismatch($sformatf("prime %0d, want %0d", prime, exp_r.prime));
            if (exponent !== exp_r.exponent)
               report_mismatch($sformatf("exponent %0d, want %0d (prime %0d)",
                                         exponent, exp_r.exponent, exp_r.prime));
            if (last !== exp_r.last)
               report_mismatch($sformatf("last %0b, want %0b (prime %0d)",
                                         last, exp_r.last, exp_r.prime));
            if (status !== exp_r.status)
               report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
         end
      endtask
   endclass

   localparam longint unsigned VALUE_MAX = 64'hFFFF_FFFF;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata = '0;  // value, divisor
   logic                        req_tuser = 1'b0; // cmd
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;        // prime, exponent, pad
   logic                        rsp_tlast;
   logic [STATUS_WIDTH-1:0]     rsp_tuser;        // status

   int unsigned send_idle_pct = 15;
   int unsigned recv_idle_pct = 61;
   int unsigned small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                     43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

   factor_scoreboard_type sb = new();

   trial_division_factorizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[DATA_WIDTH-1:0],
                           rsp_tdata[DATA_WIDTH+EXP_WIDTH-1:DATA_WIDTH],
                           rsp_tlast, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task send_request(logic cmd, logic [DATA_WIDTH-1:0] value, logic [DATA_WIDTH-1:0] divisor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, value};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(cmd, value, divisor);
   endtask

   task send_random_item();
      longint unsigned v;
      int unsigned     p;
      int unsigned     pick;
      logic [DATA_WIDTH-1:0] d;
      pick = $urandom_range(99);
      if (pick < 40) begin
         // smooth value: small primes, sometimes a cofactor below 2^16
         v = 1;
         repeat ($urandom_range(1, 8)) begin
            p = small_primes[$urandom_range(0, 24)];
            repeat ($urandom_range(1, 5))
               if (v * p <= VALUE_MAX) v = v * p;
         end
         if ($urandom_range(1)) begin
            p = $urandom_range(2, 65535);
            if (v * p <= VALUE_MAX) v = v * p;
         end
         send_request(CMD_FACTOR, v[DATA_WIDTH-1:0], $urandom);
      end else if (pick < 50) begin
         send_request(CMD_FACTOR, $urandom_range(2, 1 << 18), $urandom);
      end else if (pick < 75) begin
         d = ($urandom_range(3) == 0) ? $urandom_range(2, 1 << 16) : $urandom_range(2, 20);
         v = 1;
         repeat ($urandom_range(0, 31))
            if (v * d <= VALUE_MAX) v = v * d;
         p = $urandom_range(1, 1000);
         if (v * p <= VALUE_MAX) v = v * p;
         send_request(CMD_VALUATION, v[DATA_WIDTH-1:0], d);
      end else if (pick < 92) begin
         send_request(CMD_VALUATION, $urandom, $urandom);
      end else begin
         case ($urandom_range(2))
            0: send_request(logic'($urandom_range(1)), '0, $urandom);
            1: send_request(CMD_FACTOR, DATA_WIDTH'(1), $urandom);
            default: send_request(CMD_VALUATION, $urandom, $urandom_range(0, 1));
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // factorise: invalid, empty, powers of two, squares, max distinct primes
      send_request(CMD_FACTOR, 32'd0, 32'd0);
      send_request(CMD_FACTOR, 32'd1, 32'hFFFF_FFFF);
      send_request(CMD_FACTOR, 32'd2, 32'd0);
      send_request(CMD_FACTOR, 32'd3, 32'd0);
      send_request(CMD_FACTOR, 32'd4, 32'd0);
      send_request(CMD_FACTOR, 32'd9, 32'd0);
      send_request(CMD_FACTOR, 32'd841, 32'd0);
      send_request(CMD_FACTOR, 32'd360, 32'd0);
      send_request(CMD_FACTOR, 32'h8000_0000, 32'd0);
      send_request(CMD_FACTOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_FACTOR, 32'd1000003, 32'd0);
      send_request(CMD_FACTOR, 32'd223092870, 32'd0);
      send_request(CMD_FACTOR, 32'd12, 32'hFFFF_FFFF);
      // valuation: invalid operands, value one, non-prime divisor, extremes
      send_request(CMD_VALUATION, 32'd0, 32'd5);
      send_request(CMD_VALUATION, 32'd0, 32'd0);
      send_request(CMD_VALUATION, 32'd100, 32'd0);
      send_request(CMD_VALUATION, 32'd100, 32'd1);
      send_request(CMD_VALUATION, 32'd1, 32'd7);
      send_request(CMD_VALUATION, 32'h8000_0000, 32'd2);
      send_request(CMD_VALUATION, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_VALUATION, 32'd81, 32'd9);
      send_request(CMD_VALUATION, 32'd100, 32'd4);
      send_request(CMD_VALUATION, 32'd5, 32'd7);

      repeat (26) send_random_item();
      send_idle_pct = 61;
      recv_idle_pct = 15;
      repeat (26) send_random_item();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (26) send_random_item();
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[trial_division_factorizer] OK");
      else
         $display("[trial_division_factorizer] ERROR");
      $finish;
   end

   initial begin
      #96000000;
      $display("[trial_division_factorizer] ERROR");
      $finish;
   end

endmodule
